@@ sv/snmf_pkg.sv @@
// Shared types and constants of the system-exclusive nibble message framer.
// Used by the channel interfaces and by every module of the block.
package snmf_pkg;

	// Widths of the channel payloads, the configuration port and internal fields.
	localparam int KIND_W = 2;
	localparam int BYTE_W = 8;
	localparam int ID_W = 7;
	localparam int SUM_W = 7;
	localparam int CFG_IDX_W = 1;
	localparam int POS_W = 8;
	localparam int STEP_W = 4;

	// Input item kinds.
	localparam logic [KIND_W-1:0] KIND_PATCH = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MASTER = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MANUFACTURER_ID = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 1'd1;
	localparam logic [ID_W-1:0] MANUFACTURER_ID_RST = 7'd16;
	localparam logic [ID_W-1:0] DEVICE_ID_RST = 7'd6;

	// Message bytes.
	localparam logic [BYTE_W-1:0] SX_START = 8'hF0;
	localparam logic [BYTE_W-1:0] SX_END = 8'hF7;
	localparam logic [BYTE_W-1:0] OP_PATCH = 8'h01;
	localparam logic [BYTE_W-1:0] OP_MASTER = 8'h03;
	localparam logic [BYTE_W-1:0] OP_REQUEST = 8'h04;

	// Dump lengths in packed payload bytes.
	localparam logic [POS_W-1:0] PATCH_BYTES = 8'd134;
	localparam logic [POS_W-1:0] MASTER_BYTES = 8'd172;

	// Command queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// One command tells the back end which bytes to send for one item.
	typedef struct packed {
		logic is_request;
		logic has_trailer;
		logic [STEP_W-1:0] first_step;
		logic [BYTE_W-1:0] opcode;
		logic [BYTE_W-1:0] header_value;
		logic [BYTE_W-1:0] data_byte;
		logic [SUM_W-1:0] sum;
	} snmf_cmd_t;

endpackage

@@ sv/snmf_if.sv @@
// Valid/ready channel interfaces of the framer: input items and output bytes.
// Depends on snmf_pkg for the payload widths.
interface snmf_in_if;
	import snmf_pkg::*;

	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] header_value;
	logic [BYTE_W-1:0] data_byte;

	modport source(output valid, output kind, output header_value, output data_byte,
		input ready);
	modport sink(input valid, input kind, input header_value, input data_byte,
		output ready);
endinterface

interface snmf_out_if;
	import snmf_pkg::*;

	logic valid;
	logic ready;
	logic [BYTE_W-1:0] out_byte;
	logic run_last;
	logic message_end;

	modport source(output valid, output out_byte, output run_last, output message_end,
		input ready);
	modport sink(input valid, input out_byte, input run_last, input message_end,
		output ready);
endinterface

@@ sv/sysex_nibble_message_framer.sv @@
// System-exclusive message framer for nibble-encoded patch and master dumps.
// Items arrive on item_ch (kind, header_value, data_byte) and message bytes
// leave on byte_ch (out_byte, run_last, message_end), both valid/ready.
// A dump byte yields two nibble bytes; the first byte of a dump adds the
// five header bytes and the last adds the 7-bit sum and F7. A request
// yields seven bytes. Kind 3 is taken and yields nothing.
// The front end updates the dump position and sum in the cycle an item is
// accepted and queues a command; the back end sends one byte per cycle while
// byte_ch is ready, and an item has two bytes for a plain dump byte, up to
// nine. The first byte passes the command queue and the back end's command
// register before it reaches the output register and is valid on byte_ch.
// The two-entry command queue lets the front take the next request while
// bytes are still being sent; when byte_ch stalls, the output register
// holds its byte, the queue fills and item_ch.ready drops.
// Reset clears the open dump, empties the queue and sets manufacturer_id
// to 16 and device_id to 6. cfg_we writes cfg_wdata to register cfg_index
// (0 manufacturer_id, 1 device_id); use it only while the block is idle.
// Depends on snmf_pkg, snmf_if, snmf_front, snmf_queue and snmf_back.
module sysex_nibble_message_framer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [snmf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [snmf_pkg::ID_W-1:0]      cfg_wdata,
	snmf_in_if.sink                       item_ch,
	snmf_out_if.source                    byte_ch
);
	import snmf_pkg::*;

	logic [ID_W-1:0] manufacturer_id_q;
	logic [ID_W-1:0] device_id_q;

	logic push;
	logic pop;
	logic queue_full;
	logic queue_nonempty;
	snmf_cmd_t front_cmd;
	snmf_cmd_t queue_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manufacturer_id_q <= MANUFACTURER_ID_RST;
			device_id_q <= DEVICE_ID_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MANUFACTURER_ID: manufacturer_id_q <= cfg_wdata;
				CFG_DEVICE_ID: device_id_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	snmf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_ch(item_ch),
		.queue_full(queue_full),
		.push(push),
		.cmd(front_cmd)
	);

	snmf_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(front_cmd),
		.full(queue_full),
		.pop(pop),
		.nonempty(queue_nonempty),
		.pop_data(queue_cmd)
	);

	snmf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(queue_nonempty),
		.cmd(queue_cmd),
		.pop(pop),
		.manufacturer_id(manufacturer_id_q),
		.device_id(device_id_q),
		.byte_ch(byte_ch)
	);

endmodule

@@ sv/snmf_front.sv @@
// Front end: accepts items, tracks the open dump and turns each item into a command.
// Depends on snmf_pkg and snmf_in_if.
module snmf_front (
	input  logic                clk,
	input  logic                arst_n,
	snmf_in_if.sink             item_ch,
	input  logic                queue_full,
	output logic                push,
	output snmf_pkg::snmf_cmd_t cmd
);
	import snmf_pkg::*;

	localparam logic [STEP_W-1:0] STEP_HEADER = 4'd0;
	localparam logic [STEP_W-1:0] STEP_PAYLOAD = 4'd5;

	logic [POS_W-1:0] pos_q;
	logic [SUM_W-1:0] sum_q;
	logic open_kind_q;

	logic accept;
	logic first;
	logic okind;
	logic [SUM_W-1:0] new_sum;
	logic [POS_W-1:0] new_pos;
	logic [POS_W-1:0] size;
	logic trailer;

	assign item_ch.ready = !queue_full;
	assign accept = item_ch.valid && !queue_full;
	assign push = accept && (item_ch.kind != KIND_UNUSED);

	always_comb begin
		first = (pos_q == '0);
		okind = first ? item_ch.kind[0] : open_kind_q;
		new_sum = (first ? '0 : sum_q) + item_ch.data_byte[SUM_W-1:0];
		new_pos = pos_q + 1'b1;
		size = okind ? MASTER_BYTES : PATCH_BYTES;
		// A position that wraps to zero also closes the dump.
		trailer = (new_pos == '0) || (new_pos >= size);

		cmd.header_value = item_ch.header_value;
		cmd.data_byte = item_ch.data_byte;
		cmd.sum = new_sum;
		if (item_ch.kind == KIND_REQUEST) begin
			cmd.is_request = 1'b1;
			cmd.has_trailer = 1'b0;
			cmd.first_step = STEP_HEADER;
			cmd.opcode = OP_REQUEST;
		end else begin
			cmd.is_request = 1'b0;
			cmd.has_trailer = trailer;
			cmd.first_step = first ? STEP_HEADER : STEP_PAYLOAD;
			cmd.opcode = okind ? OP_MASTER : OP_PATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			open_kind_q <= 1'b0;
		end else if (push) begin
			if (item_ch.kind == KIND_REQUEST) begin
				// A request abandons any open dump.
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				open_kind_q <= okind;
				pos_q <= trailer ? '0 : new_pos;
				sum_q <= trailer ? '0 : new_sum;
			end
		end
	end

endmodule

@@ sv/snmf_queue.sv @@
// Short command queue that decouples the front end from the byte sequencer.
// Depends on snmf_pkg for the command type and depth.
module snmf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  snmf_pkg::snmf_cmd_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                nonempty,
	output snmf_pkg::snmf_cmd_t pop_data
);
	import snmf_pkg::*;

	snmf_cmd_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/snmf_back.sv @@
// Back end: steps through the bytes of each command into a registered output.
// Depends on snmf_pkg and snmf_out_if.
module snmf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  snmf_pkg::snmf_cmd_t cmd,
	output logic                pop,
	input  logic [snmf_pkg::ID_W-1:0] manufacturer_id,
	input  logic [snmf_pkg::ID_W-1:0] device_id,
	snmf_out_if.source          byte_ch
);
	import snmf_pkg::*;

	localparam logic [STEP_W-1:0] STEP_START = 4'd0;
	localparam logic [STEP_W-1:0] STEP_MFR = 4'd1;
	localparam logic [STEP_W-1:0] STEP_DEV = 4'd2;
	localparam logic [STEP_W-1:0] STEP_OPCODE = 4'd3;
	localparam logic [STEP_W-1:0] STEP_VALUE = 4'd4;
	localparam logic [STEP_W-1:0] STEP_LOW = 4'd5;
	localparam logic [STEP_W-1:0] STEP_HIGH = 4'd6;
	localparam logic [STEP_W-1:0] STEP_SUM = 4'd7;
	localparam logic [STEP_W-1:0] STEP_END = 4'd8;

	snmf_cmd_t cur_q;
	logic busy_q;
	logic [STEP_W-1:0] step_q;

	logic out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic run_last_q;
	logic message_end_q;

	logic slot_free;
	logic emit;
	logic [BYTE_W-1:0] next_byte;
	logic is_last;
	logic is_end;

	assign slot_free = !out_valid_q || byte_ch.ready;
	assign emit = busy_q && slot_free;

	// The step numbering is shared; a request reuses the value and payload steps
	// for its data byte, header value and closing byte.
	always_comb begin
		case (step_q)
			STEP_START: next_byte = SX_START;
			STEP_MFR: next_byte = {1'b0, manufacturer_id};
			STEP_DEV: next_byte = {1'b0, device_id};
			STEP_OPCODE: next_byte = cur_q.opcode;
			STEP_VALUE: next_byte = cur_q.is_request ? cur_q.data_byte : cur_q.header_value;
			STEP_LOW: next_byte = cur_q.is_request ? cur_q.header_value
				: {4'b0000, cur_q.data_byte[3:0]};
			STEP_HIGH: next_byte = cur_q.is_request ? SX_END
				: {4'b0000, cur_q.data_byte[7:4]};
			STEP_SUM: next_byte = {1'b0, cur_q.sum};
			STEP_END: next_byte = SX_END;
			default: next_byte = SX_END;
		endcase
		is_end = (cur_q.is_request && step_q == STEP_HIGH) || (step_q == STEP_END);
		if (cur_q.has_trailer) begin
			is_last = (step_q == STEP_END);
		end else begin
			is_last = (step_q == STEP_HIGH);
		end
	end

	assign pop = cmd_valid && (!busy_q || (emit && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= cmd.first_step;
			end else if (emit) begin
				busy_q <= !is_last;
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= next_byte;
			run_last_q <= is_last;
			message_end_q <= is_end;
		end
	end

	assign byte_ch.valid = out_valid_q;
	assign byte_ch.out_byte = out_byte_q;
	assign byte_ch.run_last = run_last_q;
	assign byte_ch.message_end = message_end_q;

endmodule
